// ===== hdl/edt_pkg.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// edt_pkg
// Shared types and constants for the expiring duplicate suppression table:
// result status codes, controller states and the control/status bundles
// passed between the controller and the datapath.
// -----------------------------------------------------------------------------
package edt_pkg;

   // Field widths fixed by the channel definitions
   localparam int KEY_WORD_W = 64;
   localparam int KEY_W      = 4 * KEY_WORD_W;
   localparam int TIME_W     = 63;
   localparam int INTERVAL_W = 64;
   localparam int LIMIT_W    = 12;
   localparam int STATUS_W   = 3;
   localparam int COUNT_W    = 12;

   // Window clamp: one century of days
   localparam logic [63:0] DAYS_PER_CENTURY = 64'd36500;
   localparam logic [63:0] SECONDS_PER_DAY  = 64'd86400;
   localparam logic [63:0] MAX_WINDOW       = DAYS_PER_CENTURY * SECONDS_PER_DAY;
   localparam int          WINDOW_W         = 32;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 12'd2000;

   // Result status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_GRANTED_OPEN     = 3'd0,
      ST_GRANTED_RECORDED = 3'd1,
      ST_DENIED_SEEN      = 3'd2,
      ST_DENIED_FULL      = 3'd3,
      ST_CLEARED          = 3'd4
   } edt_status_type;

   // Controller states
   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_CLEAR,
      S_WALK,
      S_DRAIN,
      S_DECIDE,
      S_RESULT
   } edt_state_type;

   // Controller to datapath
   typedef struct packed {
      logic           capture;
      logic           sweep_clear;
      logic           walk_read;
      logic           insert;
      logic           load_result;
      edt_status_type code;
   } edt_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic req_is_clear;
      logic req_no_window;
      logic addr_last;
      logic seen;
      logic full;
   } edt_stat_type;

endpackage
`default_nettype wire

// ===== hdl/edt_req_if.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// edt_req_if
// Request channel: opcode, 256-bit key digest, current time and window.
// -----------------------------------------------------------------------------
interface edt_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 opcode;
   logic [edt_pkg::KEY_WORD_W-1:0]       key_word_0;
   logic [edt_pkg::KEY_WORD_W-1:0]       key_word_1;
   logic [edt_pkg::KEY_WORD_W-1:0]       key_word_2;
   logic [edt_pkg::KEY_WORD_W-1:0]       key_word_3;
   logic [edt_pkg::TIME_W-1:0]           now_seconds;
   logic signed [edt_pkg::INTERVAL_W-1:0] interval_seconds;

   modport source (
      output valid, opcode, key_word_0, key_word_1, key_word_2, key_word_3,
             now_seconds, interval_seconds,
      input  ready
   );

   modport sink (
      input  valid, opcode, key_word_0, key_word_1, key_word_2, key_word_3,
             now_seconds, interval_seconds,
      output ready
   );
endinterface
`default_nettype wire

// ===== hdl/edt_rsp_if.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// edt_rsp_if
// Response channel: status code, grant flag and live entry count.
// -----------------------------------------------------------------------------
interface edt_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [edt_pkg::STATUS_W-1:0]   status;
   logic                           granted;
   logic [edt_pkg::COUNT_W-1:0]    live_count;

   modport source (
      output valid, status, granted, live_count,
      input  ready
   );

   modport sink (
      input  valid, status, granted, live_count,
      output ready
   );
endinterface
`default_nettype wire

// ===== hdl/edt_ctrl.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// edt_ctrl
// Controller: sequences the post-reset clearing pass, clear sweeps, table
// walks and the final insert, and owns the request/response handshakes.
// -----------------------------------------------------------------------------
module edt_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output edt_pkg::edt_cmd_type     cmd,
   input  wire edt_pkg::edt_stat_type stat
);

   edt_pkg::edt_state_type  state_ff, state_in;
   edt_pkg::edt_status_type code_ff, code_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    out_free;

   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // State, pending code and output valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= edt_pkg::S_INIT;
         code_ff      <= edt_pkg::ST_GRANTED_OPEN;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         code_ff      <= code_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in        = state_ff;
      code_in         = code_ff;
      req_ready       = 1'b0;
      cmd             = '0;
      cmd.code        = code_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;

      case (state_ff)
         edt_pkg::S_INIT: begin
            cmd.sweep_clear = 1'b1;
            if (stat.addr_last) begin
               state_in = edt_pkg::S_IDLE;
            end
         end
         edt_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               if (stat.req_is_clear) begin
                  code_in  = edt_pkg::ST_CLEARED;
                  state_in = edt_pkg::S_CLEAR;
               end else if (stat.req_no_window) begin
                  code_in  = edt_pkg::ST_GRANTED_OPEN;
                  state_in = edt_pkg::S_RESULT;
               end else begin
                  state_in = edt_pkg::S_WALK;
               end
            end
         end
         edt_pkg::S_CLEAR: begin
            cmd.sweep_clear = 1'b1;
            if (stat.addr_last) begin
               state_in = edt_pkg::S_RESULT;
            end
         end
         edt_pkg::S_WALK: begin
            cmd.walk_read = 1'b1;
            if (stat.addr_last) begin
               state_in = edt_pkg::S_DRAIN;
            end
         end
         edt_pkg::S_DRAIN: begin
            // last slot is evaluated in this cycle
            state_in = edt_pkg::S_DECIDE;
         end
         edt_pkg::S_DECIDE: begin
            if (stat.seen) begin
               code_in = edt_pkg::ST_DENIED_SEEN;
            end else if (stat.full) begin
               code_in = edt_pkg::ST_DENIED_FULL;
            end else begin
               cmd.insert = 1'b1;
               code_in    = edt_pkg::ST_GRANTED_RECORDED;
            end
            state_in = edt_pkg::S_RESULT;
         end
         edt_pkg::S_RESULT: begin
            // hold until the output register is free
            if (out_free) begin
               cmd.load_result = 1'b1;
               rsp_valid_in    = 1'b1;
               state_in        = edt_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = edt_pkg::S_INIT;
         end
      endcase
   end

endmodule
`default_nettype wire

// ===== hdl/edt_datapath.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// edt_datapath
// Datapath: entry memories (valid, expiry, key), the slot address counter,
// the walk evaluation stage with prune/match/count/free-slot search, the
// stored-entry count, the limit register and the response register.
// -----------------------------------------------------------------------------
module edt_datapath #(
   parameter int TABLE_DEPTH = 2048
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire edt_pkg::edt_cmd_type                  cmd,
   output edt_pkg::edt_stat_type                      stat,
   input  wire logic                                  csr_write_enable,
   input  wire logic [edt_pkg::LIMIT_W-1:0]           csr_write_data,
   input  wire logic                                  req_opcode,
   input  wire logic [edt_pkg::KEY_WORD_W-1:0]        req_key_word_0,
   input  wire logic [edt_pkg::KEY_WORD_W-1:0]        req_key_word_1,
   input  wire logic [edt_pkg::KEY_WORD_W-1:0]        req_key_word_2,
   input  wire logic [edt_pkg::KEY_WORD_W-1:0]        req_key_word_3,
   input  wire logic [edt_pkg::TIME_W-1:0]            req_now_seconds,
   input  wire logic signed [edt_pkg::INTERVAL_W-1:0] req_interval_seconds,
   output logic [edt_pkg::STATUS_W-1:0]               rsp_status,
   output logic                                       rsp_granted,
   output logic [edt_pkg::COUNT_W-1:0]                rsp_live_count
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int CMP_W = (CNT_W > edt_pkg::LIMIT_W) ? CNT_W : edt_pkg::LIMIT_W;
   localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(TABLE_DEPTH - 1);

   // Entry memories
   logic                            valid_mem  [TABLE_DEPTH];
   logic [edt_pkg::TIME_W-1:0]      expiry_mem [TABLE_DEPTH];
   logic [edt_pkg::KEY_W-1:0]       key_mem    [TABLE_DEPTH];

   // Held request
   logic [edt_pkg::KEY_W-1:0]       key_ff;
   logic [edt_pkg::TIME_W-1:0]      now_ff;
   logic [edt_pkg::WINDOW_W-1:0]    window_ff, window_in;
   logic [edt_pkg::TIME_W-1:0]      expiry_ff, expiry_in;
   logic [edt_pkg::TIME_W:0]        expiry_sum;

   // Sweep and walk
   logic [IDX_W-1:0]                addr_ff, addr_in;
   logic                            eval_valid_ff;
   logic [IDX_W-1:0]                eval_addr_ff;
   logic                            rd_valid_ff;
   logic [edt_pkg::TIME_W-1:0]      rd_expiry_ff;
   logic [edt_pkg::KEY_W-1:0]       rd_key_ff;
   logic                            expired, live_hit, prune;

   // Walk accumulators and counts
   logic [CNT_W-1:0]                live_ff, live_in;
   logic                            seen_ff, seen_in;
   logic                            have_free_ff, have_free_in;
   logic [IDX_W-1:0]                free_slot_ff, free_slot_in;
   logic [CNT_W-1:0]                stored_ff, stored_in;
   logic [edt_pkg::LIMIT_W-1:0]     live_limit_ff;

   // Memory write port
   logic                            mem_we;
   logic [IDX_W-1:0]                mem_waddr;

   // Response register
   logic [edt_pkg::STATUS_W-1:0]    rsp_status_ff;
   logic                            rsp_granted_ff;
   logic [edt_pkg::COUNT_W-1:0]     rsp_count_ff;
   logic [CNT_W-1:0]                rsp_count_sel;

   assign rsp_status     = rsp_status_ff;
   assign rsp_granted    = rsp_granted_ff;
   assign rsp_live_count = rsp_count_ff;

   // Classify the incoming request
   assign stat.req_is_clear  = req_opcode;
   assign stat.req_no_window = (req_interval_seconds == '0) ||
                               req_interval_seconds[edt_pkg::INTERVAL_W-1];
   assign stat.addr_last     = (addr_ff == LAST_ADDR);
   assign stat.seen          = seen_ff;
   assign stat.full          = (CMP_W'(live_ff) >= CMP_W'(live_limit_ff)) || !have_free_ff;

   // Clamp the window to one century
   always_comb begin
      if ($unsigned(req_interval_seconds) > edt_pkg::MAX_WINDOW) begin
         window_in = edt_pkg::MAX_WINDOW[edt_pkg::WINDOW_W-1:0];
      end else begin
         window_in = req_interval_seconds[edt_pkg::WINDOW_W-1:0];
      end
   end

   // Saturating expiry from the held time and window
   assign expiry_sum = {1'b0, now_ff} + (edt_pkg::TIME_W + 1)'(window_ff);
   assign expiry_in  = expiry_sum[edt_pkg::TIME_W] ? '1 : expiry_sum[edt_pkg::TIME_W-1:0];

   // Hold request fields
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         key_ff    <= {req_key_word_3, req_key_word_2, req_key_word_1, req_key_word_0};
         now_ff    <= req_now_seconds;
         window_ff <= window_in;
      end
      expiry_ff <= expiry_in;
   end

   // Slot address: restart on capture, advance during sweeps and walks
   always_comb begin
      addr_in = addr_ff;
      if (cmd.capture) begin
         addr_in = '0;
      end else if (cmd.sweep_clear || cmd.walk_read) begin
         addr_in = stat.addr_last ? '0 : addr_ff + IDX_W'(1);
      end
   end

   // Evaluate one read-back slot
   assign expired  = rd_valid_ff && (rd_expiry_ff <= now_ff);
   assign prune    = eval_valid_ff && expired;
   assign live_hit = eval_valid_ff && rd_valid_ff && !expired;

   always_comb begin
      live_in      = live_ff;
      seen_in      = seen_ff;
      have_free_in = have_free_ff;
      free_slot_in = free_slot_ff;
      if (cmd.capture) begin
         live_in      = '0;
         seen_in      = 1'b0;
         have_free_in = 1'b0;
         free_slot_in = '0;
      end else if (cmd.insert) begin
         live_in = live_ff + CNT_W'(1);
      end else if (live_hit) begin
         live_in = live_ff + CNT_W'(1);
         if (rd_key_ff == key_ff) begin
            seen_in = 1'b1;
         end
      end else if (eval_valid_ff && !have_free_ff) begin
         have_free_in = 1'b1;
         free_slot_in = eval_addr_ff;
      end
   end

   // Stored entries, expired or not
   always_comb begin
      stored_in = stored_ff;
      if (cmd.sweep_clear) begin
         stored_in = '0;
      end else if (cmd.insert) begin
         stored_in = stored_ff + CNT_W'(1);
      end else if (prune) begin
         stored_in = stored_ff - CNT_W'(1);
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff       <= '0;
         eval_valid_ff <= 1'b0;
         stored_ff     <= '0;
         live_limit_ff <= edt_pkg::LIMIT_RESET;
      end else begin
         addr_ff       <= addr_in;
         eval_valid_ff <= cmd.walk_read;
         stored_ff     <= stored_in;
         if (csr_write_enable) begin
            live_limit_ff <= csr_write_data;
         end
      end
   end

   // Walk accumulators
   always_ff @(posedge clock) begin
      eval_addr_ff <= addr_ff;
      live_ff      <= live_in;
      seen_ff      <= seen_in;
      have_free_ff <= have_free_in;
      free_slot_ff <= free_slot_in;
   end

   // Valid memory write: clear sweep, prune or insert
   assign mem_we    = cmd.sweep_clear || prune || cmd.insert;
   always_comb begin
      if (cmd.sweep_clear) begin
         mem_waddr = addr_ff;
      end else if (cmd.insert) begin
         mem_waddr = free_slot_ff;
      end else begin
         mem_waddr = eval_addr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         valid_mem[mem_waddr] <= cmd.insert;
      end
      if (cmd.walk_read) begin
         rd_valid_ff <= valid_mem[addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.insert) begin
         expiry_mem[free_slot_ff] <= expiry_ff;
      end
      if (cmd.walk_read) begin
         rd_expiry_ff <= expiry_mem[addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.insert) begin
         key_mem[free_slot_ff] <= key_ff;
      end
      if (cmd.walk_read) begin
         rd_key_ff <= key_mem[addr_ff];
      end
   end

   // Pick the reported count for each outcome
   always_comb begin
      case (cmd.code)
         edt_pkg::ST_CLEARED:      rsp_count_sel = '0;
         edt_pkg::ST_GRANTED_OPEN: rsp_count_sel = stored_ff;
         default:                  rsp_count_sel = live_ff;
      endcase
   end

   // Response register
   always_ff @(posedge clock) begin
      if (cmd.load_result) begin
         rsp_status_ff  <= cmd.code;
         rsp_granted_ff <= (cmd.code == edt_pkg::ST_GRANTED_OPEN) ||
                           (cmd.code == edt_pkg::ST_GRANTED_RECORDED);
         rsp_count_ff   <= edt_pkg::COUNT_W'(rsp_count_sel);
      end
   end

endmodule
`default_nettype wire

// ===== hdl/expiring_dedup_table_unit.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// expiring_dedup_table_unit
// Time-window duplicate suppression table for one account, built as a
// controller and a datapath around one-read, one-write entry memories.
// -----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the valid memory and takes
// no request until it ends; csr writes are taken at any time. One request is
// handled at a time. A claim with a positive window walks every slot through
// the single memory read port (prune, match, count, free-slot search) before
// the next request is accepted. A claim with no window goes straight to the
// result, and a clear request sweeps the valid memory. Responses sit in an
// output register, so a new request is accepted while the previous response
// is still waiting to be taken.
// -----------------------------------------------------------------------------
module expiring_dedup_table_unit #(
   parameter int TABLE_DEPTH = 2048
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   edt_req_if.sink                          req_if,
   edt_rsp_if.source                        rsp_if,
   input  wire logic                        csr_write_enable,
   input  wire logic [edt_pkg::LIMIT_W-1:0] csr_write_data
);

   edt_pkg::edt_cmd_type  cmd;
   edt_pkg::edt_stat_type stat;

   // Sequencing and handshakes
   edt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   // Table storage and evaluation
   edt_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .stat                 (stat),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data),
      .req_opcode           (req_if.opcode),
      .req_key_word_0       (req_if.key_word_0),
      .req_key_word_1       (req_if.key_word_1),
      .req_key_word_2       (req_if.key_word_2),
      .req_key_word_3       (req_if.key_word_3),
      .req_now_seconds      (req_if.now_seconds),
      .req_interval_seconds (req_if.interval_seconds),
      .rsp_status           (rsp_if.status),
      .rsp_granted          (rsp_if.granted),
      .rsp_live_count       (rsp_if.live_count)
   );

endmodule
`default_nettype wire

// ===== bench/expiring_dedup_table_unit_tb.sv =====
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// expiring_dedup_table_unit_tb
// Self-checking bench for the duplicate suppression table. A small table
// depth keeps the per-claim walk short. A scoreboard keeps its own copy of the
// table and of the live limit and works out each response as requests are
// accepted. Directed corner requests come first, then phases of random
// claims and clears under several live limits and handshake throttling.
// -----------------------------------------------------------------------------
module expiring_dedup_table_unit_tb;

   localparam int DEPTH           = 16;
   localparam logic OP_CLAIM      = 1'b0;
   localparam logic OP_CLEAR      = 1'b1;
   localparam logic [63:0] WINDOW_CAP = 64'd36500 * 64'd86400;
   localparam logic [edt_pkg::TIME_W-1:0] STAMP_MAX = '1;
   localparam logic [edt_pkg::KEY_W-1:0] KEY_A = {4{64'h0123_4567_89ab_cdef}};
   localparam logic [edt_pkg::KEY_W-1:0] KEY_B = {4{64'hfedc_ba98_7654_3210}};
   localparam int KEY_POOL        = 10;
   localparam int NUM_PHASES      = 9;
   localparam int ITEMS_PER_PHASE = 30;
   localparam int HOLD_PHASE      = 6;
   localparam int LONG_HOLD       = 400;
   localparam int SETTLE_CYCLES   = DEPTH + 16;
   localparam int WATCHDOG_NS     = 5_000_000;

   typedef struct packed {
      logic                           opcode;
      logic [edt_pkg::KEY_W-1:0]      key;
      logic [edt_pkg::TIME_W-1:0]     stamp;
      logic [edt_pkg::INTERVAL_W-1:0] interval;
   } dedup_request_type;

   typedef struct packed {
      edt_pkg::edt_status_type     status;
      logic                        granted;
      logic [edt_pkg::COUNT_W-1:0] live_count;
   } verdict_type;

   logic                         clock = 1'b0;
   logic                         reset;
   logic                         csr_write_enable;
   logic [edt_pkg::LIMIT_W-1:0]  csr_write_data;

   edt_req_if req_bus ();
   edt_rsp_if rsp_bus ();

   expiring_dedup_table_unit #(
      .TABLE_DEPTH(DEPTH)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_if          (req_bus),
      .rsp_if          (rsp_bus),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data)
   );

   // Scoreboard copy of the table and its limit
   logic                         slot_live   [DEPTH];
   logic [edt_pkg::KEY_W-1:0]    slot_key    [DEPTH];
   logic [edt_pkg::TIME_W-1:0]   slot_expiry [DEPTH];
   logic [edt_pkg::LIMIT_W-1:0]  live_limit;

   dedup_request_type pending_requests [$];
   verdict_type       expected_verdicts [$];
   dedup_request_type offered_request;
   verdict_type       due;
   int             requests_queued   = 0;
   int             requests_accepted = 0;
   int             mismatch_count    = 0;
   int             sender_idle_pct;
   int             receiver_idle_pct;
   int             stalls_requested  = 0;
   int             stalls_served     = 0;
   int             hold_left         = 0;
   logic [edt_pkg::LIMIT_W-1:0] limit_plan [NUM_PHASES] = '{
      12'd4095, 12'd0, 12'd1, 12'd2048, 12'd5, 12'd16, 12'd17, 12'd2000, 12'd9
   };
   logic [edt_pkg::KEY_W-1:0] key_pool [KEY_POOL];

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [edt_pkg::KEY_W-1:0] rand_key();
      return {rand64(), rand64(), rand64(), rand64()};
   endfunction

   // Work out the response to one request and update the table copy
   function automatic verdict_type judge_request(input dedup_request_type r);
      verdict_type v;
      logic [63:0] window;
      logic [63:0] expiry;
      int          live;
      int          free_slot;
      bit          have_free;
      bit          seen;
      live      = 0;
      free_slot = 0;
      have_free = 1'b0;
      seen      = 1'b0;
      if (r.opcode == OP_CLEAR) begin
         foreach (slot_live[i]) slot_live[i] = 1'b0;
         v.status     = edt_pkg::ST_CLEARED;
         v.granted    = 1'b0;
         v.live_count = '0;
         return v;
      end
      // No window: grant, leave the table alone, expired entries still count
      if (r.interval == '0 || r.interval[63]) begin
         foreach (slot_live[i]) if (slot_live[i]) live++;
         v.status     = edt_pkg::ST_GRANTED_OPEN;
         v.granted    = 1'b1;
         v.live_count = edt_pkg::COUNT_W'(live);
         return v;
      end
      window = (r.interval > WINDOW_CAP) ? WINDOW_CAP : r.interval;
      // Prune, match, count and find the lowest free slot in one pass
      for (int i = 0; i < DEPTH; i++) begin
         if (slot_live[i] && slot_expiry[i] <= r.stamp)
            slot_live[i] = 1'b0;
         if (slot_live[i]) begin
            live++;
            if (slot_key[i] == r.key)
               seen = 1'b1;
         end else if (!have_free) begin
            have_free = 1'b1;
            free_slot = i;
         end
      end
      v.granted    = 1'b0;
      v.live_count = edt_pkg::COUNT_W'(live);
      if (seen) begin
         v.status = edt_pkg::ST_DENIED_SEEN;
         return v;
      end
      if (live >= int'(live_limit) || !have_free) begin
         v.status = edt_pkg::ST_DENIED_FULL;
         return v;
      end
      // Record with saturating expiry
      expiry = {1'b0, r.stamp} + window;
      if (expiry > {1'b0, STAMP_MAX})
         expiry = {1'b0, STAMP_MAX};
      slot_live[free_slot]   = 1'b1;
      slot_key[free_slot]    = r.key;
      slot_expiry[free_slot] = expiry[edt_pkg::TIME_W-1:0];
      v.status     = edt_pkg::ST_GRANTED_RECORDED;
      v.granted    = 1'b1;
      v.live_count = edt_pkg::COUNT_W'(live + 1);
      return v;
   endfunction

   task automatic queue_request(input logic op, input logic [edt_pkg::KEY_W-1:0] key,
                                input logic [edt_pkg::TIME_W-1:0] stamp,
                                input logic [edt_pkg::INTERVAL_W-1:0] interval);
      dedup_request_type r;
      r.opcode   = op;
      r.key      = key;
      r.stamp    = stamp;
      r.interval = interval;
      pending_requests = {pending_requests, r};
      requests_queued++;
   endtask

   task automatic wait_drained();
      while (requests_accepted != requests_queued || expected_verdicts.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_live_limit(input logic [edt_pkg::LIMIT_W-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      live_limit = value;
   endtask

   // Request driver: score accepted requests, then offer the next one
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            expected_verdicts = {expected_verdicts, judge_request(offered_request)};
            requests_accepted++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_requests.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
               offered_request = pending_requests.pop_front();
               req_bus.valid            <= 1'b1;
               req_bus.opcode           <= offered_request.opcode;
               req_bus.key_word_0       <= offered_request.key[63:0];
               req_bus.key_word_1       <= offered_request.key[127:64];
               req_bus.key_word_2       <= offered_request.key[191:128];
               req_bus.key_word_3       <= offered_request.key[255:192];
               req_bus.now_seconds      <= offered_request.stamp;
               req_bus.interval_seconds <= offered_request.interval;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: compare against the oldest expectation, throttle ready
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_verdicts.size() == 0) begin
               $error("response with no request outstanding");
               mismatch_count++;
            end else begin
               due = expected_verdicts.pop_front();
               if (rsp_bus.status !== due.status) begin
                  $error("status: expected %0d, got %0d", due.status, rsp_bus.status);
                  mismatch_count++;
               end
               if (rsp_bus.granted !== due.granted) begin
                  $error("granted: expected %0d, got %0d", due.granted, rsp_bus.granted);
                  mismatch_count++;
               end
               if (rsp_bus.live_count !== due.live_count) begin
                  $error("live_count: expected %0d, got %0d", due.live_count,
                         rsp_bus.live_count);
                  mismatch_count++;
               end
            end
         end
         // Hold off for a long stretch when asked, else throttle at random
         if (stalls_served != stalls_requested) begin
            hold_left = LONG_HOLD;
            stalls_served++;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
         end
      end
   end

   // Stimulus
   initial begin
      int                             roll;
      int                             pick;
      logic                           op;
      logic [edt_pkg::KEY_W-1:0]      key;
      logic [edt_pkg::TIME_W-1:0]     stamp;
      logic [edt_pkg::TIME_W-1:0]     base_stamp;
      logic [edt_pkg::INTERVAL_W-1:0] interval;
      reset                    = 1'b1;
      csr_write_enable         = 1'b0;
      csr_write_data           = '0;
      req_bus.valid            = 1'b0;
      req_bus.opcode           = OP_CLAIM;
      req_bus.key_word_0       = '0;
      req_bus.key_word_1       = '0;
      req_bus.key_word_2       = '0;
      req_bus.key_word_3       = '0;
      req_bus.now_seconds      = '0;
      req_bus.interval_seconds = '0;
      rsp_bus.ready            = 1'b0;
      foreach (slot_live[i]) slot_live[i] = 1'b0;
      live_limit        = edt_pkg::LIMIT_RESET;
      sender_idle_pct   = 32;
      receiver_idle_pct = 45;
      limit_plan[NUM_PHASES-1] = edt_pkg::LIMIT_W'($urandom_range(2, 15));
      base_stamp = 63'd1000;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: repeat, expiry at exactly now, no window, clamp, saturation
      queue_request(OP_CLAIM, KEY_A, 63'd100, 64'd10);
      queue_request(OP_CLAIM, KEY_A, 63'd105, 64'd10);
      queue_request(OP_CLAIM, KEY_A, 63'd110, 64'd10);
      queue_request(OP_CLAIM, KEY_B, 63'd111, 64'd0);
      queue_request(OP_CLAIM, KEY_B, 63'd111, 64'hffff_ffff_ffff_ffff);
      queue_request(OP_CLAIM, KEY_B, 63'd111, 64'h8000_0000_0000_0000);
      queue_request(OP_CLAIM, '1, STAMP_MAX, 64'h7fff_ffff_ffff_ffff);
      queue_request(OP_CLAIM, '0, 63'd0, 64'd1);
      queue_request(OP_CLAIM, 256'd1, 63'd0, WINDOW_CAP);
      queue_request(OP_CLAIM, 256'd1 << 255, 63'd0, WINDOW_CAP + 64'd1);
      queue_request(OP_CLAIM, '0, 63'd0, 64'd5);
      queue_request(OP_CLAIM, '1, 63'd1, 64'd1);
      queue_request(OP_CLAIM, KEY_B, 63'd2, -64'sd5);
      queue_request(OP_CLEAR, rand_key(), edt_pkg::TIME_W'(rand64()), rand64());
      queue_request(OP_CLEAR, rand_key(), edt_pkg::TIME_W'(rand64()), rand64());
      queue_request(OP_CLAIM, KEY_B, 63'd3, 64'd0);
      queue_request(OP_CLAIM, KEY_B, 63'd50, 64'd20);
      queue_request(OP_CLAIM, {64'h1, KEY_A[191:0]}, 63'd50, 64'd20);
      queue_request(OP_CLAIM, KEY_A, 63'd500, 64'd0);
      queue_request(OP_CLAIM, KEY_A, 63'd500, 64'd3);
      queue_request(OP_CLAIM, KEY_A, 63'd501, 64'd3);
      wait_drained();

      // Random phases, each under its own live limit
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase * 3 / NUM_PHASES)
            0: begin
               sender_idle_pct   = 32;
               receiver_idle_pct = 45;
            end
            1: begin
               sender_idle_pct   = 45;
               receiver_idle_pct = 32;
            end
            default: begin
               sender_idle_pct   = 0;
               receiver_idle_pct = 0;
            end
         endcase
         write_live_limit(limit_plan[phase]);
         foreach (key_pool[k]) key_pool[k] = rand_key();
         if (phase == HOLD_PHASE)
            stalls_requested++;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            roll = $urandom_range(0, 99);
            op   = (roll < 3) ? OP_CLEAR : OP_CLAIM;
            // Mostly pooled keys so repeats happen, some near misses and fresh keys
            pick = $urandom_range(0, 19);
            if (pick == 0)
               key = rand_key();
            else if (pick == 1)
               key = key_pool[$urandom_range(0, KEY_POOL-1)] ^
                     (256'd1 << $urandom_range(0, edt_pkg::KEY_W-1));
            else
               key = key_pool[$urandom_range(0, KEY_POOL-1)];
            // Advance time slowly, now and then jump anywhere
            base_stamp = base_stamp + edt_pkg::TIME_W'($urandom_range(0, 6));
            stamp = ($urandom_range(0, 19) == 0) ? edt_pkg::TIME_W'(rand64()) : base_stamp;
            roll = $urandom_range(0, 99);
            if (roll < 50)
               interval = 64'($urandom_range(1, 30));
            else if (roll < 72)
               interval = 64'($urandom_range(100, 100000));
            else if (roll < 80)
               interval = {1'b0, 63'(rand64())};
            else if (roll < 85)
               interval = rand64();
            else if (roll < 95)
               interval = {1'b1, 63'(rand64())};
            else
               interval = '0;
            queue_request(op, key, stamp, interval);
         end
         wait_drained();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_verdicts.size() != 0) begin
         $error("%0d responses never arrived", expected_verdicts.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #(WATCHDOG_NS);
      $display("Mismatches found");
      $finish;
   end

endmodule
